// ----- rtl/lobm_pkg.sv -----
// types and constants shared by the order book matcher
package lobm_pkg;

	localparam logic [1:0] KIND_LIMIT  = 2'd0;
	localparam logic [1:0] KIND_MARKET = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] ident;
		logic        is_sell;
		logic [31:0] limit_price;
		logic [23:0] amount;
	} lobm_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        bid_present;
		logic [31:0] best_bid;
		logic        ask_present;
		logic [31:0] best_ask;
		logic [6:0]  resting_count;
		logic [23:0] filled_amount;
	} lobm_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_STATS,
		S_DONE
	} lobm_state_t;

endpackage

// ----- rtl/limit_order_book_matcher.sv -----
// limit order book matcher: top level with slot memory and scan sequencer
// One request is taken while busy is low. A sequencer walks the book one entry
// per cycle with a single shared compare unit. Slot memory is read through a
// registered port. Every request first sweeps the book (id match, lowest free
// slot, and best opposite entry for a market order), and a final sweep builds
// best bid and ask. A market order adds a fill step for each resting order it
// touches and one further sweep after each fill that leaves quantity. The
// result is on rsp while done is high for one cycle, and busy drops in the
// cycle after; the receiver cannot stall it. No clearing pass is needed after
// reset: slot valid bits are flip-flops.
module limit_order_book_matcher #(
	parameter int BOOK_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lobm_pkg::lobm_req_t req,
	output logic                busy,
	output logic                done,
	output lobm_pkg::lobm_rsp_t rsp
);
	import lobm_pkg::*;

	localparam int IW = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
	localparam int CW = $clog2(BOOK_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(BOOK_ENTRIES - 1);

	// slot storage
	logic [BOOK_ENTRIES-1:0] used_q;
	logic [31:0] ident_mem [BOOK_ENTRIES];
	logic        sell_mem  [BOOK_ENTRIES];
	logic [31:0] price_mem [BOOK_ENTRIES];
	logic [23:0] left_mem  [BOOK_ENTRIES];
	logic [31:0] arr_mem   [BOOK_ENTRIES];

	lobm_state_t state_q, state_d;
	lobm_req_t   req_q;
	logic [IW-1:0] idx_q;
	logic          issue_q;
	logic [31:0] arrival_q;
	logic [CW-1:0] count_q;

	// scan results
	logic          hit_q, free_ok_q, best_ok_q, phase_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, best_idx_q;
	logic [31:0]   best_price_q, best_arr_q;
	logic [23:0]   best_left_q;
	logic [23:0]   qty_q, filled_q;
	logic [1:0]    status_q;
	logic          bid_ok_q, ask_ok_q;
	logic [31:0]   bid_q, ask_q;

	// registered read of the entry addressed last cycle
	logic          used_s1, sell_s1, look_s1;
	logic [31:0]   ident_s1, price_s1, arr_s1;
	logic [23:0]   left_s1;
	logic [IW-1:0] idx_s1;

	always_ff @(posedge clk) begin
		used_s1  <= used_q[idx_q];
		ident_s1 <= ident_mem[idx_q];
		sell_s1  <= sell_mem[idx_q];
		price_s1 <= price_mem[idx_q];
		left_s1  <= left_mem[idx_q];
		arr_s1   <= arr_mem[idx_q];
	end

	// sweep end and id / free slot results including the entry in hand
	logic          sweep_end, id_match, hit_now, free_now;
	logic [IW-1:0] hit_at, free_at;
	always_comb begin
		sweep_end = look_s1 && (idx_s1 == LAST);
		id_match  = look_s1 && phase_q && used_s1 && (ident_s1 == req_q.ident);
		hit_now   = hit_q || id_match;
		hit_at    = hit_q ? hit_idx_q : idx_s1;
		free_now  = free_ok_q || (look_s1 && phase_q && !used_s1);
		free_at   = free_ok_q ? free_idx_q : idx_s1;
	end

	// shared compare: is current entry a better match than best so far
	logic cand, better;
	always_comb begin
		cand = look_s1 && used_s1 && (sell_s1 != req_q.is_sell) && (left_s1 != '0);
		if (!best_ok_q)
			better = 1'b1;
		else if (price_s1 != best_price_q)
			better = req_q.is_sell ? (price_s1 > best_price_q) : (price_s1 < best_price_q);
		else
			better = arr_s1 < best_arr_q;
	end

	logic [23:0] take;
	always_comb begin
		take = (qty_q < best_left_q) ? qty_q : best_left_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_SCAN;
			S_SCAN: begin
				if (sweep_end) begin
					if (phase_q && req_q.kind == KIND_MARKET && !hit_now)
						state_d = S_FILL;
					else if (!phase_q && (best_ok_q || (cand && better)))
						state_d = S_FILL;
					else
						state_d = S_STATS;
				end
			end
			S_FILL: begin
				if (!best_ok_q || qty_q == '0)
					state_d = S_STATS;
				else if (qty_q - take == '0)
					state_d = S_STATS;
				else
					state_d = S_SCAN;
			end
			S_STATS: if (sweep_end) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		rsp.status        = status_q;
		rsp.bid_present   = bid_ok_q;
		rsp.best_bid      = bid_q;
		rsp.ask_present   = ask_ok_q;
		rsp.best_ask      = ask_q;
		rsp.resting_count = 7'(count_q);
		rsp.filled_amount = filled_q;
	end

	// control and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			arrival_q <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			issue_q   <= 1'b0;
			idx_s1    <= '0;
			look_s1   <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					issue_q <= 1'b1;
					look_s1 <= 1'b0;
					phase_q <= 1'b1;
				end
				S_SCAN, S_STATS: begin
					idx_s1  <= idx_q;
					look_s1 <= issue_q;
					if (sweep_end) begin
						idx_q   <= '0;
						issue_q <= 1'b1;
					end else if (issue_q) begin
						if (idx_q == LAST)
							issue_q <= 1'b0;
						else
							idx_q <= idx_q + 1'b1;
					end
					if (state_q == S_SCAN && sweep_end && phase_q) begin
						phase_q <= 1'b0;
						// apply limit add or cancel after the first scan
						if (req_q.kind == KIND_LIMIT && !hit_now
						    && CW'(BOOK_ENTRIES) != count_q && free_now) begin
							used_q[free_at] <= 1'b1;
							arrival_q <= arrival_q + 1'b1;
							count_q   <= count_q + 1'b1;
						end else if (req_q.kind == KIND_CANCEL && hit_now) begin
							used_q[hit_at] <= 1'b0;
							count_q <= count_q - 1'b1;
						end
					end
				end
				S_FILL: begin
					look_s1 <= 1'b0;
					if (best_ok_q && qty_q != '0 && best_left_q == take) begin
						used_q[best_idx_q] <= 1'b0;
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q     <= req;
				qty_q     <= req.amount;
				filled_q  <= '0;
				hit_q     <= 1'b0;
				free_ok_q <= 1'b0;
				best_ok_q <= 1'b0;
			end
			S_SCAN: begin
				if (id_match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (look_s1 && phase_q && !used_s1 && !free_ok_q) begin
					free_ok_q  <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (cand && better) begin
					best_ok_q    <= 1'b1;
					best_idx_q   <= idx_s1;
					best_price_q <= price_s1;
					best_arr_q   <= arr_s1;
					best_left_q  <= left_s1;
				end
				if (sweep_end && phase_q) begin
					if ((req_q.kind == KIND_LIMIT || req_q.kind == KIND_MARKET) && hit_now)
						status_q <= ST_DUP;
					else if (req_q.kind == KIND_LIMIT) begin
						if (CW'(BOOK_ENTRIES) == count_q || !free_now)
							status_q <= ST_FULL;
						else begin
							status_q <= ST_OK;
							ident_mem[free_at] <= req_q.ident;
							sell_mem[free_at]  <= req_q.is_sell;
							price_mem[free_at] <= req_q.limit_price;
							left_mem[free_at]  <= req_q.amount;
							arr_mem[free_at]   <= arrival_q;
						end
					end else if (req_q.kind == KIND_CANCEL && !hit_now)
						status_q <= ST_UNKNOWN;
					else
						status_q <= ST_OK;
				end
			end
			S_FILL: begin
				if (best_ok_q && qty_q != '0) begin
					left_mem[best_idx_q] <= best_left_q - take;
					qty_q    <= qty_q - take;
					filled_q <= filled_q + take;
				end
				best_ok_q <= 1'b0;
				bid_ok_q  <= 1'b0;
				ask_ok_q  <= 1'b0;
				bid_q     <= '0;
				ask_q     <= '0;
			end
			S_STATS: begin
				if (look_s1 && used_s1) begin
					if (sell_s1) begin
						if (!ask_ok_q || price_s1 < ask_q) ask_q <= price_s1;
						ask_ok_q <= 1'b1;
					end else begin
						if (!bid_ok_q || price_s1 > bid_q) bid_q <= price_s1;
						bid_ok_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
		// entry to stats straight from scan clears the summary
		if (state_q == S_SCAN && state_d == S_STATS) begin
			bid_ok_q <= 1'b0;
			ask_ok_q <= 1'b0;
			bid_q    <= '0;
			ask_q    <= '0;
		end
	end

endmodule

// ----- bench/limit_order_book_matcher_tb.sv -----
// self-checking testbench for the limit order book matcher
`timescale 1ns / 1ps

module limit_order_book_matcher_tb;
	import lobm_pkg::*;

	localparam int BOOK = 64;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 40000;
	localparam int POOL = 80;

	logic clk;
	logic arst_n;
	logic start;
	lobm_req_t req;
	logic busy;
	logic done;
	lobm_rsp_t rsp;

	limit_order_book_matcher #(.BOOK_ENTRIES(BOOK)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// order book shadow
	bit          book_used[BOOK];
	logic [31:0] book_ident[BOOK];
	logic        book_sell[BOOK];
	logic [31:0] book_price[BOOK];
	logic [23:0] book_left[BOOK];
	logic [31:0] book_stamp[BOOK];
	logic [31:0] stamp_next;
	int          book_count;

	lobm_req_t   pending_reqs[$];
	bit          drain_first[$];
	lobm_rsp_t   expected_rsps[$];
	logic [31:0] id_pool[POOL];
	int          failures;
	int          idle_cycles;
	int          gap_left;
	bit          took;

	always #5 clk = ~clk;

	function automatic int find_order(logic [31:0] id);
		for (int i = 0; i < BOOK; i++)
			if (book_used[i] && book_ident[i] == id)
				return i;
		return -1;
	endfunction

	// best resting entry on the opposite side, price then arrival
	function automatic int best_counter(logic taker_sells);
		int best;
		best = -1;
		for (int i = 0; i < BOOK; i++) begin
			if (!book_used[i] || book_sell[i] == taker_sells || book_left[i] == 0)
				continue;
			if (best < 0)
				best = i;
			else if (book_price[i] != book_price[best]) begin
				if (taker_sells ? book_price[i] > book_price[best]
						: book_price[i] < book_price[best])
					best = i;
			end else if (book_stamp[i] < book_stamp[best])
				best = i;
		end
		return best;
	endfunction

	function automatic lobm_rsp_t apply_request(lobm_req_t r);
		lobm_rsp_t o;
		logic [23:0] qty;
		logic [23:0] take;
		int m;
		int slot;
		o = '0;
		qty = r.amount;
		if (r.kind == KIND_LIMIT || r.kind == KIND_MARKET) begin
			if (find_order(r.ident) >= 0)
				o.status = ST_DUP;
			else if (r.kind == KIND_MARKET) begin
				// sweep the opposite side until filled or empty
				for (int n = 0; n < BOOK && qty > 0; n++) begin
					m = best_counter(r.is_sell);
					if (m < 0)
						break;
					take = qty < book_left[m] ? qty : book_left[m];
					qty -= take;
					o.filled_amount += take;
					book_left[m] -= take;
					if (book_left[m] == 0) begin
						book_used[m] = 0;
						book_count--;
					end
				end
			end else if (book_count >= BOOK)
				o.status = ST_FULL;
			else begin
				slot = 0;
				while (book_used[slot])
					slot++;
				book_used[slot] = 1;
				book_ident[slot] = r.ident;
				book_sell[slot] = r.is_sell;
				book_price[slot] = r.limit_price;
				book_left[slot] = r.amount;
				book_stamp[slot] = stamp_next;
				stamp_next++;
				book_count++;
			end
		end else if (r.kind == KIND_CANCEL) begin
			slot = find_order(r.ident);
			if (slot < 0)
				o.status = ST_UNKNOWN;
			else begin
				book_used[slot] = 0;
				book_count--;
			end
		end
		// top of book
		for (int i = 0; i < BOOK; i++) begin
			if (!book_used[i])
				continue;
			if (book_sell[i]) begin
				if (!o.ask_present || book_price[i] < o.best_ask)
					o.best_ask = book_price[i];
				o.ask_present = 1;
			end else begin
				if (!o.bid_present || book_price[i] > o.best_bid)
					o.best_bid = book_price[i];
				o.bid_present = 1;
			end
		end
		o.resting_count = book_count[6:0];
		return o;
	endfunction

	function automatic logic [31:0] pick_price();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return $urandom;
			default: return 32'd1000 + $urandom_range(0, 15);
		endcase
	endfunction

	function automatic logic [23:0] pick_amount(int cap);
		case ($urandom_range(0, 24))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(1, cap));
		endcase
	endfunction

	task automatic queue_req(logic [1:0] k, logic [31:0] id, logic s, logic [31:0] p,
			logic [23:0] a, bit hold);
		lobm_req_t r;
		r.kind = k;
		r.ident = id;
		r.is_sell = s;
		r.limit_price = p;
		r.amount = a;
		pending_reqs = {pending_reqs, r};
		drain_first = {drain_first, hold};
	endtask

	// random request, mix weighted by a per-phase profile
	task automatic queue_random(int limit_w, int market_w, bit fresh_ids, bit hold);
		int roll;
		logic [31:0] id;
		roll = $urandom_range(0, 99);
		id = fresh_ids ? $urandom : id_pool[$urandom_range(0, POOL - 1)];
		if (roll < limit_w)
			queue_req(KIND_LIMIT, id, 1'($urandom_range(0, 1)), pick_price(),
				pick_amount(50), hold);
		else if (roll < limit_w + market_w)
			queue_req(KIND_MARKET, $urandom_range(0, 9) == 0 ? id_pool[0] : $urandom,
				1'($urandom_range(0, 1)), $urandom, pick_amount(200), hold);
		else if (roll < 97)
			queue_req(KIND_CANCEL, $urandom_range(0, 5) == 0 ? $urandom : id,
				1'($urandom), $urandom, 24'($urandom), hold);
		else
			queue_req(KIND_SPARE, $urandom, 1'($urandom), $urandom, 24'($urandom), hold);
	endtask

	// request accepted: predict its response
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_rsps = {expected_rsps, apply_request(req)};
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n || (start && !took)) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_reqs.size() == 0 ||
				(drain_first[0] && expected_rsps.size() != 0)) begin
			start <= 1'b0;
		end else begin
			req <= pending_reqs.pop_front();
			void'(drain_first.pop_front());
			start <= 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: gap_left <= $urandom_range(1, 3);
				3: gap_left <= $urandom_range(20, 300);
				default: gap_left <= 0;
			endcase
		end
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("response with no request outstanding");
				failures++;
			end else begin
				lobm_rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status);
					failures++;
				end
				if (rsp.bid_present !== e.bid_present) begin
					$error("bid_present exp %0d got %0d", e.bid_present, rsp.bid_present);
					failures++;
				end
				if (rsp.best_bid !== e.best_bid) begin
					$error("best_bid exp %0d got %0d", e.best_bid, rsp.best_bid);
					failures++;
				end
				if (rsp.ask_present !== e.ask_present) begin
					$error("ask_present exp %0d got %0d", e.ask_present, rsp.ask_present);
					failures++;
				end
				if (rsp.best_ask !== e.best_ask) begin
					$error("best_ask exp %0d got %0d", e.best_ask, rsp.best_ask);
					failures++;
				end
				if (rsp.resting_count !== e.resting_count) begin
					$error("resting_count exp %0d got %0d", e.resting_count,
						rsp.resting_count);
					failures++;
				end
				if (rsp.filled_amount !== e.filled_amount) begin
					$error("filled_amount exp %0d got %0d", e.filled_amount,
						rsp.filled_amount);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles without progress
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		start = 0;
		req = '0;
		failures = 0;
		idle_cycles = 0;
		gap_left = 0;
		took = 0;
		stamp_next = '0;
		book_count = 0;
		for (int i = 0; i < BOOK; i++)
			book_used[i] = 0;
		for (int i = 0; i < POOL; i++)
			id_pool[i] = $urandom;

		// directed: extremes, every kind, priority and corner cases
		queue_req(KIND_LIMIT, 32'd0, 1'b0, 32'd0, 24'hFFFFFF, 0);
		queue_req(KIND_LIMIT, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 24'd1, 0);
		queue_req(KIND_LIMIT, 32'd0, 1'b1, 32'd5, 24'd3, 0);
		queue_req(KIND_MARKET, 32'hFFFFFFFF, 1'b0, 32'd0, 24'd3, 0);
		queue_req(KIND_LIMIT, 32'h10, 1'b1, 32'd50, 24'd0, 0);
		queue_req(KIND_LIMIT, 32'h11, 1'b1, 32'd60, 24'd4, 0);
		queue_req(KIND_LIMIT, 32'h12, 1'b1, 32'd60, 24'd4, 0);
		queue_req(KIND_LIMIT, 32'h13, 1'b1, 32'd70, 24'd9, 0);
		queue_req(KIND_MARKET, 32'h14, 1'b0, 32'd0, 24'd0, 0);
		queue_req(KIND_MARKET, 32'h15, 1'b0, 32'd0, 24'd6, 0);
		queue_req(KIND_MARKET, 32'h16, 1'b0, 32'hFFFFFFFF, 24'hFFFFFF, 0);
		queue_req(KIND_LIMIT, 32'h20, 1'b0, 32'd90, 24'd2, 0);
		queue_req(KIND_LIMIT, 32'h21, 1'b0, 32'd95, 24'd2, 0);
		queue_req(KIND_MARKET, 32'h22, 1'b1, 32'd0, 24'd3, 0);
		queue_req(KIND_MARKET, 32'h23, 1'b1, 32'd0, 24'hFFFFFF, 0);
		queue_req(KIND_CANCEL, 32'h10, 1'b0, 32'd0, 24'd0, 0);
		queue_req(KIND_CANCEL, 32'h10, 1'b1, 32'd0, 24'd0, 0);
		queue_req(KIND_CANCEL, 32'h0, 1'b0, 32'd0, 24'd0, 0);
		queue_req(KIND_SPARE, 32'h30, 1'b1, 32'd7, 24'd7, 0);
		queue_req(KIND_CANCEL, 32'hFFFFFFFF, 1'b0, 32'd0, 24'd0, 1);

		// random phases; each phase waits for the book to settle first
		for (int ph = 0; ph < 9; ph++) begin
			for (int n = 0; n < 100; n++) begin
				case (ph % 3)
					0: queue_random(60, 20, 0, n == 0);
					1: queue_random(85, 5, ph == 4 || ph == 7, n == 0);
					default: queue_random(25, 45, 0, n == 0);
				endcase
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// wait until the last request is taken and answered
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start);
		repeat (300) @(posedge clk);
		if (failures == 0 && expected_rsps.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
